// ===== src/its_pkg.sv =====
// Shared types and constants for the index tracking sorter.
package its_pkg;

    localparam int VALUE_W = 32;
    localparam int POS_W   = 6;

    // One stored sample with its arrival tag.
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [POS_W-1:0]          pos;
    } t_entry;

    // Per-cycle command broadcast to every cell of the chain.
    typedef struct packed {
        logic insert;
        logic drain;
    } t_cell_ctrl;

endpackage

// ===== src/index_tracking_sorter_unit.sv =====
// Top level of the index tracking sorter: a chain of insertion cells.
//
//   channel  | handshake        | payload
//   ---------+------------------+--------------------------------------------
//   sample   | start / busy     | i_sample_value, i_batch_end
//   result   | o_valid (strobe) | o_sorted_value, o_original_position,
//            |                  | o_run_end
//
// A sample is inserted in its sorted place in the cycle it is accepted, so
// samples may arrive back to back; a sample sent while the chain is full is
// dropped. A sample marked as batch end starts a drain that shifts the chain
// toward cell 0, one result per cycle, with busy high throughout. Reset empties
// the chain at once. Results cannot be stalled.
module index_tracking_sorter_unit
    import its_pkg::*;
#(
    parameter int MAX_ITEMS = 64
)
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic signed [VALUE_W-1:0] i_sample_value,
    input  logic                      i_batch_end,
    output logic                      o_valid,
    output logic signed [VALUE_W-1:0] o_sorted_value,
    output logic [POS_W-1:0]          o_original_position,
    output logic                      o_run_end
);

    localparam int CNT_W = $clog2(MAX_ITEMS + 1);

    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;
    logic                 r_drain;
    logic                 n_drain;
    logic                 w_accept;
    logic                 w_full;
    t_cell_ctrl           w_ctrl;
    t_entry               w_new;
    t_entry               w_entry [MAX_ITEMS];
    logic [MAX_ITEMS-1:0] w_occ;
    logic [MAX_ITEMS-1:0] w_greater;

    assign busy     = r_drain;
    assign w_accept = start && !r_drain;
    assign w_full   = (r_count == CNT_W'(MAX_ITEMS));

    assign w_ctrl.insert = w_accept && !w_full;
    assign w_ctrl.drain  = r_drain;
    assign w_new.value   = i_sample_value;
    assign w_new.pos     = POS_W'(r_count);

    for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
        t_entry w_left_entry;
        logic   w_left_occ;
        logic   w_left_greater;
        t_entry w_right_entry;
        logic   w_right_occ;

        if (i == 0) begin : g_head
            assign w_left_entry   = w_new;
            assign w_left_occ     = 1'b1;
            assign w_left_greater = 1'b0;
        end else begin : g_mid_left
            assign w_left_entry   = w_entry[i-1];
            assign w_left_occ     = w_occ[i-1];
            assign w_left_greater = w_greater[i-1];
        end

        if (i == MAX_ITEMS - 1) begin : g_tail
            assign w_right_entry = w_new;
            assign w_right_occ   = 1'b0;
        end else begin : g_mid_right
            assign w_right_entry = w_entry[i+1];
            assign w_right_occ   = w_occ[i+1];
        end

        its_cell u_cell (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_ctrl         (w_ctrl),
            .i_new          (w_new),
            .i_left_entry   (w_left_entry),
            .i_left_occ     (w_left_occ),
            .i_left_greater (w_left_greater),
            .i_right_entry  (w_right_entry),
            .i_right_occ    (w_right_occ),
            .o_entry        (w_entry[i]),
            .o_occ          (w_occ[i]),
            .o_greater      (w_greater[i])
        );
    end

    always_comb begin
        n_count = r_count;
        n_drain = r_drain;
        priority if (r_drain) begin
            // The drain ends on the item that leaves cell 0 when cell 1 is empty.
            if (!w_occ[1]) begin
                n_drain = 1'b0;
                n_count = '0;
            end
        end else if (w_accept) begin
            if (!w_full) begin
                n_count = r_count + CNT_W'(1);
            end
            n_drain = i_batch_end;
        end else begin
            n_count = r_count;
            n_drain = r_drain;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_drain <= 1'b0;
        end else begin
            r_count <= n_count;
            r_drain <= n_drain;
        end
    end

    assign o_valid             = r_drain;
    assign o_sorted_value      = w_entry[0].value;
    assign o_original_position = w_entry[0].pos;
    assign o_run_end           = r_drain && !w_occ[1];

`ifndef SYNTH
    a_valid_has_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> w_occ[0])
        else $error("result strobe with empty head cell");

    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_drain |-> ($countones(w_occ) == int'(r_count)))
        else $error("item count disagrees with occupied cells");

    a_occ_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_occ >> 1) & ~w_occ) == '0)
        else $error("occupied cells are not contiguous from the head");

    a_head_not_greater: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.insert && w_occ[0] && !w_greater[0] |->
            (w_entry[0].value <= i_sample_value))
        else $error("head compare flag inconsistent");

    a_run_end_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_run_end |=> (!busy && r_count == '0 && w_occ == '0))
        else $error("drain did not finish after last result");
`endif

endmodule

// ===== src/its_cell.sv =====
// One cell of the sorting chain: holds a single entry and its occupancy bit.
module its_cell
    import its_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell_ctrl i_ctrl,
    input  t_entry     i_new,
    input  t_entry     i_left_entry,
    input  logic       i_left_occ,
    input  logic       i_left_greater,
    input  t_entry     i_right_entry,
    input  logic       i_right_occ,
    output t_entry     o_entry,
    output logic       o_occ,
    output logic       o_greater
);

    t_entry r_entry;
    t_entry n_entry;
    logic   r_occ;
    logic   n_occ;

    // An empty cell counts as greater than any sample, so the flags along the
    // chain are false before the insertion point and true from it on.
    assign o_greater = !r_occ || (r_entry.value > i_new.value);

    always_comb begin
        n_entry = r_entry;
        n_occ   = r_occ;
        priority if (i_ctrl.drain) begin
            n_entry = i_right_entry;
            n_occ   = i_right_occ;
        end else if (i_ctrl.insert && o_greater) begin
            n_entry = i_left_greater ? i_left_entry : i_new;
            n_occ   = r_occ | i_left_occ;
        end else begin
            n_entry = r_entry;
            n_occ   = r_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        if (!i_rst_n) begin
            r_occ <= 1'b0;
        end else begin
            r_occ <= n_occ;
        end
    end

    assign o_entry = r_entry;
    assign o_occ   = r_occ;

endmodule
